// ----- design/hrr_pkg.sv -----
// Package for the hashed random range generator: field widths, hash constants,
// operation and work codes, and the request, result and work item structs.
// No dependencies.
package hrr_pkg;

   localparam int HASH_W = 32;
   localparam int THR_W = 14;
   localparam int OP_W = 2;

   localparam int HRR_QUEUE_DEPTH = 4;

   localparam logic [HASH_W-1:0] HASH_XOR = 32'd61;
   localparam int HASH_SHIFT_A = 16;
   localparam int HASH_SHIFT_B = 4;
   localparam int HASH_SHIFT_C = 15;
   localparam int HASH_MUL9_SHIFT = 3;
   localparam logic [HASH_W-1:0] HASH_MUL = 32'd668265261;

   localparam logic [HASH_W-1:0] PROB_SCALE = 32'd10000;
   localparam logic [HASH_W-1:0] PROB_SPAN = PROB_SCALE + 32'd1;

   typedef enum logic [OP_W-1:0] {
      OP_RAW = 2'd0,
      OP_RANGE = 2'd1,
      OP_PROB = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      WM_BYPASS,
      WM_REDUCE,
      WM_PROB
   } work_mode_type;

   typedef struct packed {
      logic [OP_W-1:0] operation;
      logic [HASH_W-1:0] seed;
      logic [HASH_W-1:0] range_min;
      logic [HASH_W-1:0] range_max;
      logic [THR_W-1:0] threshold;
   } req_type;

   typedef struct packed {
      logic [HASH_W-1:0] value;
      logic hit;
   } rsp_type;

   typedef struct packed {
      work_mode_type mode;
      logic [HASH_W-1:0] hash;
      logic [HASH_W-1:0] divisor;
      logic [HASH_W-1:0] addend;
      logic [THR_W-1:0] threshold;
   } work_type;

   typedef struct packed {
      work_type work;
      logic [HASH_W-1:0] rem;
   } div_type;

endpackage

// ----- design/hrr_front.sv -----
// Front end: accepts requests, runs the three-stage hash pipeline and
// classifies each request into a work item. Depends on hrr_pkg.
module hrr_front
   import hrr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  req_type req_data,
   input  logic q_full,
   output logic q_push,
   output work_type q_data
);

   logic v1_ff, v2_ff, v3_ff;
   work_type s1_ff, s2_ff, s3_ff;
   work_type s1_in, s2_in, s3_in;
   logic adv;
   logic [HASH_W-1:0] mix;
   logic [HASH_W-1:0] span;
   logic [HASH_W-1:0] h2;

   assign adv = !v3_ff || !q_full;
   assign req_full = !adv;
   assign q_push = v3_ff && !q_full;
   assign q_data = s3_ff;

   always_comb begin
      mix = (req_data.seed ^ HASH_XOR) ^ (req_data.seed >> HASH_SHIFT_A);
      span = req_data.range_max - req_data.range_min + 32'd1;
      s1_in.hash = mix + (mix << HASH_MUL9_SHIFT);
      s1_in.threshold = req_data.threshold;
      case (req_data.operation)
         OP_RANGE: begin
            s1_in.addend = req_data.range_min;
            if (span == '0) begin
               s1_in.mode = WM_BYPASS;
               s1_in.divisor = 32'd1;
            end else begin
               s1_in.mode = WM_REDUCE;
               s1_in.divisor = span;
            end
         end
         OP_PROB: begin
            s1_in.mode = WM_PROB;
            s1_in.divisor = PROB_SPAN;
            s1_in.addend = '0;
         end
         default: begin
            s1_in.mode = WM_BYPASS;
            s1_in.divisor = 32'd1;
            s1_in.addend = '0;
         end
      endcase
   end

   always_comb begin
      h2 = s1_ff.hash ^ (s1_ff.hash >> HASH_SHIFT_B);
      s2_in = s1_ff;
      s2_in.hash = h2 * HASH_MUL;
   end

   always_comb begin
      s3_in = s2_ff;
      s3_in.hash = s2_ff.hash ^ (s2_ff.hash >> HASH_SHIFT_C);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_push;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
      end
   end

   a_front_advance: assert property (@(posedge clock) disable iff (reset)
      (adv && v1_ff) |=> v2_ff)
      else $error("hash pipeline dropped an item");

endmodule

// ----- design/hrr_queue.sv -----
// Short register queue of work items between the front and back ends.
// Depends on hrr_pkg.
module hrr_queue
   import hrr_pkg::*;
#(
   parameter int Depth = HRR_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  work_type push_data,
   output logic full,
   input  logic pop,
   output work_type pop_data,
   output logic empty
);

   localparam int PtrW = $clog2(Depth);
   localparam int CountW = $clog2(Depth + 1);

   work_type entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CountW'(Depth));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(Depth))
      else $error("work queue count beyond depth");

endmodule

// ----- design/hrr_back.sv -----
// Back end: one-bit-per-stage restoring remainder pipeline, then the output
// register that adds the offset and sets the hit flag. Depends on hrr_pkg.
module hrr_back
   import hrr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic q_empty,
   output logic q_pop,
   input  work_type q_data,
   output logic rsp_empty,
   input  logic rsp_pop,
   output rsp_type rsp_data
);

   localparam int Steps = HASH_W;

   logic [Steps-1:0] valid_ff;
   div_type stage_ff [Steps];
   div_type stage_in [Steps];
   logic out_v_ff;
   rsp_type rsp_ff, rsp_in;
   logic adv;
   div_type last;

   assign adv = !out_v_ff || rsp_pop;
   assign q_pop = adv && !q_empty;
   assign rsp_empty = !out_v_ff;
   assign rsp_data = rsp_ff;
   assign last = stage_ff[Steps-1];

   for (genvar k = 0; k < Steps; k++) begin : g_step
      div_type src;
      logic [HASH_W:0] partial;
      logic [HASH_W:0] diff;
      if (k == 0) begin : g_head
         assign src = '{work: q_data, rem: '0};
      end else begin : g_body
         assign src = stage_ff[k-1];
      end
      assign partial = {src.rem, src.work.hash[HASH_W-1-k]};
      assign diff = partial - {1'b0, src.work.divisor};
      assign stage_in[k] = '{work: src.work,
                             rem: diff[HASH_W] ? partial[HASH_W-1:0] : diff[HASH_W-1:0]};
   end

   always_comb begin
      rsp_in.hit = 1'b0;
      case (last.work.mode)
         WM_BYPASS: rsp_in.value = last.work.hash + last.work.addend;
         WM_REDUCE: rsp_in.value = last.rem + last.work.addend;
         WM_PROB: begin
            rsp_in.value = last.rem;
            rsp_in.hit = (last.rem <= {{(HASH_W-THR_W){1'b0}}, last.work.threshold});
         end
         default: rsp_in.value = last.work.hash;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= {valid_ff[Steps-2:0], q_pop};
         out_v_ff <= valid_ff[Steps-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
         rsp_ff <= rsp_in;
      end
   end

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff[Steps-1] |-> (last.rem < last.work.divisor))
      else $error("remainder not reduced below divisor");

   a_hit_in_scale: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && rsp_ff.hit) |-> (rsp_ff.value <= PROB_SCALE))
      else $error("hit flagged on a draw above scale");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> valid_ff[0])
      else $error("work item lost entering remainder pipeline");

endmodule

// ----- design/hashed_random_range_generator_top.sv -----
// Top level of the hashed random range generator: hash front end, work queue
// and remainder back end. Depends on hrr_pkg, hrr_front, hrr_queue, hrr_back.
//
//   channel   ports                        handshake
//   request   req_push req_full req_data   taken when req_push and not req_full
//   result    rsp_empty rsp_pop rsp_data   taken when rsp_pop and not rsp_empty
//
// One request per cycle sustained while results are taken; each request passes 3 hash
// stages, one queue slot, 32 remainder stages (one quotient bit each) and the output
// register, 37 register stages counting the accepting edge.
// Reset clears the pipeline valid bits and queue pointers; no storage needs clearing.
// A result left waiting stalls the whole back end; the front keeps taking requests
// until the QueueDepth-entry queue is full and its last hash stage holds a request.
module hashed_random_range_generator_top
   import hrr_pkg::*;
#(
   parameter int QueueDepth = HRR_QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_push,
   output logic req_full,
   input  req_type req_data,
   output logic rsp_empty,
   input  logic rsp_pop,
   output rsp_type rsp_data
);

   logic q_push, q_full, q_pop, q_empty;
   work_type q_in, q_out;

   hrr_front u_front (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .q_full(q_full),
      .q_push(q_push),
      .q_data(q_in)
   );

   hrr_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_in),
      .full(q_full),
      .pop(q_pop),
      .pop_data(q_out),
      .empty(q_empty)
   );

   hrr_back u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_pop(q_pop),
      .q_data(q_out),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

endmodule

// ----- verif/hashed_random_range_generator_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench for hashed_random_range_generator_top: drives directed and random requests
// through the queue handshakes and checks every result against a local hash predictor.
// Depends on hrr_pkg and hashed_random_range_generator_top.
module hashed_random_range_generator_top_tb;
   import hrr_pkg::*;

   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
   localparam logic [HASH_W-1:0] WORD_MAX = 32'hFFFF_FFFF;
   localparam logic [THR_W-1:0] THR_MAX = 14'h3FFF;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT = 200000;

   class draw_scoreboard;
      rsp_type pending[$];
      int mismatches;

      function new();
         mismatches = 0;
      endfunction

      function rsp_type predict_draw(req_type r);
         logic [HASH_W-1:0] h;
         logic [HASH_W-1:0] span;
         rsp_type o;
         h = (r.seed ^ HASH_XOR) ^ (r.seed >> 16);
         h = h * 32'd9;
         h = h ^ (h >> 4);
         h = h * HASH_MUL;
         h = h ^ (h >> 15);
         o.value = h;
         o.hit = 1'b0;
         if (r.operation == OP_RANGE) begin
            span = r.range_max - r.range_min + 32'd1;
            o.value = ((span == '0) ? h : (h % span)) + r.range_min;
         end else if (r.operation == OP_PROB) begin
            o.value = h % PROB_SPAN;
            o.hit = (o.value <= {{(HASH_W-THR_W){1'b0}}, r.threshold});
         end
         return o;
      endfunction

      function void note_request(req_type r);
         pending.insert(pending.size(), predict_draw(r));
      endfunction

      task report_mismatch(string what, logic [HASH_W-1:0] got, logic [HASH_W-1:0] want);
         $display("MISMATCH %0t: %s got %h expected %h", $time, what, got, want);
         mismatches++;
      endtask

      task check_result(rsp_type r);
         rsp_type want;
         if (pending.size() == 0) begin
            report_mismatch("result with no request waiting", r.value, '0);
         end else begin
            want = pending.pop_front();
            if (r.value !== want.value) report_mismatch("value", r.value, want.value);
            if (r.hit !== want.hit) report_mismatch("hit", HASH_W'(r.hit), HASH_W'(want.hit));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   rsp_type rsp_data;

   draw_scoreboard draws;
   bit allow_idle = 1'b0;
   int cycle_count = 0;

   hashed_random_range_generator_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_data(req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_push && !req_full) draws.note_request(req_data);
      if (!reset && rsp_pop && !rsp_empty) draws.check_result(rsp_data);
   end

   function automatic req_type make_request(logic [OP_W-1:0] op, logic [HASH_W-1:0] seed,
                                            logic [HASH_W-1:0] lo, logic [HASH_W-1:0] hi,
                                            logic [THR_W-1:0] thr);
      req_type r;
      r.operation = op;
      r.seed = seed;
      r.range_min = lo;
      r.range_max = hi;
      r.threshold = thr;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type r;
      logic [HASH_W-1:0] base;
      int pick;
      base = $urandom;
      pick = $urandom_range(0, 9);
      r.operation = (pick < 1) ? OP_SPARE : (pick < 3) ? OP_RAW :
                    (pick < 7) ? OP_RANGE : OP_PROB;
      r.seed = $urandom;
      r.range_min = base;
      case ($urandom_range(0, 5))
         0: r.range_max = base + $urandom_range(0, 15);
         1: r.range_max = base + $urandom_range(0, 1000000);
         2: r.range_max = base;
         3: begin
            r.range_min = '0;
            r.range_max = WORD_MAX;
         end
         default: r.range_max = $urandom;
      endcase
      r.threshold = ($urandom_range(0, 3) == 0) ? THR_W'($urandom_range(0, THR_MAX))
                                                : THR_W'($urandom_range(0, PROB_SCALE));
      return r;
   endfunction

   task send_request(req_type r);
      if (allow_idle && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
   endtask

   initial begin
      wait (!reset);
      forever begin
         if (allow_idle && $urandom_range(0, 4) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("hashed_random_range_generator_top verification failed");
      $finish;
   end

   initial begin
      draws = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      allow_idle = 1'b1;

      send_request(make_request(OP_RAW, '0, '0, '0, '0));
      send_request(make_request(OP_RAW, WORD_MAX, WORD_MAX, WORD_MAX, THR_MAX));
      send_request(make_request(OP_RAW, 32'h0000_003D, '0, '0, '0));
      send_request(make_request(OP_RANGE, 32'h1234_5678, '0, WORD_MAX, '0));
      send_request(make_request(OP_RANGE, 32'h8765_4321, 32'd1, '0, '0));
      send_request(make_request(OP_RANGE, 32'hDEAD_BEEF, 32'd77, 32'd77, '0));
      send_request(make_request(OP_RANGE, WORD_MAX, WORD_MAX, WORD_MAX, '0));
      send_request(make_request(OP_RANGE, 32'h0BAD_F00D, 32'hF000_0000, 32'h0000_0010, '0));
      send_request(make_request(OP_RANGE, 32'h0000_0001, '0, 32'd1, '0));
      send_request(make_request(OP_RANGE, 32'hCAFE_0000, 32'd100, 32'd199, '0));
      send_request(make_request(OP_RANGE, 32'h5555_AAAA, '0, 32'h7FFF_FFFF, '0));
      send_request(make_request(OP_RANGE, 32'hAAAA_5555, WORD_MAX, '0, '0));
      send_request(make_request(OP_PROB, 32'h0000_0010, '0, '0, '0));
      send_request(make_request(OP_PROB, 32'h0000_0011, '0, '0, PROB_SCALE[THR_W-1:0]));
      send_request(make_request(OP_PROB, 32'h0000_0012, '0, '0, 14'd9999));
      send_request(make_request(OP_PROB, 32'h0000_0013, '0, '0, THR_MAX));
      send_request(make_request(OP_PROB, 32'h0000_0014, '0, '0, 14'd10001));
      send_request(make_request(OP_PROB, WORD_MAX, WORD_MAX, WORD_MAX, 14'd5000));
      send_request(make_request(OP_SPARE, 32'h0F0F_F0F0, 32'd5, 32'd9, THR_MAX));
      send_request(make_request(OP_SPARE, '0, '0, '0, '0));

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         allow_idle = (i < 300) || (i >= 450 && i < 650);
         send_request(random_request());
      end
      req_push <= 1'b0;

      while (draws.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (draws.mismatches == 0)
         $display("hashed_random_range_generator_top verification clean");
      else
         $display("hashed_random_range_generator_top verification failed");
      $finish;
   end

endmodule

// ----- hashed_random_range_generator_top.f -----
design/hrr_pkg.sv
design/hrr_front.sv
design/hrr_queue.sv
design/hrr_back.sv
design/hashed_random_range_generator_top.sv
verif/hashed_random_range_generator_top_tb.sv
